/* sv/gmca_pkg.sv */
// Shared types and constants for the grid minimum component area block.
`timescale 1ns / 1ps
package gmca_pkg;

  localparam int AREA_W = 13;
  localparam int CFG_W  = 7;

  // configuration register indexes
  localparam logic CFG_ROW_COUNT = 1'b0;
  localparam logic CFG_COL_COUNT = 1'b1;

  typedef struct packed {
    logic cell_open;
    logic last_cell;
  } in_item_t;

  typedef struct packed {
    logic [AREA_W-1:0] min_area;
    logic              no_component;
  } out_item_t;

  // classified cell on its way to the fill engine
  typedef struct packed {
    logic cell_open;
    logic last_cell;
    logic store;
  } cmd_t;

endpackage

/* sv/grid_min_component_area_top.sv */
// Top level: smallest 4-connected open region of a streamed binary grid.
// Loading: one cell per cycle while the two-entry command queue has room.
// Fill after last_cell: scanned cells are read and checked, then region cells are popped
//   and their neighbours checked (single-port memories); result, then a rows*cols visited clear.
// Reset: synchronous active low; a MAX_DIM*MAX_DIM visited clear follows, during which
//   at most two cells transfer before in_stall rises (config writes taken throughout).
`timescale 1ns / 1ps
module grid_min_component_area_top import gmca_pkg::*; #(
  parameter int MAX_DIM = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  in_item_t         in_data,
  output logic             in_stall,
  output logic             out_valid,
  output out_item_t        out_data,
  input  logic             out_stall,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int CELLS = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(CELLS);
  localparam int IW    = $clog2(CELLS + 1);
  localparam int DW    = $clog2(MAX_DIM + 1);
  localparam int CW    = $clog2(MAX_DIM);

  logic [CFG_W-1:0] row_cfg_r, row_cfg_nxt;
  logic [CFG_W-1:0] col_cfg_r, col_cfg_nxt;
  logic [DW-1:0]    rows, cols;
  logic [IW-1:0]    total;

  logic q_full, q_empty, q_push, q_pop;
  cmd_t push_cmd, pop_cmd;

  // Clamp a register value into 1..MAX_DIM.
  function automatic logic [DW-1:0] clamp_dim(input logic [CFG_W-1:0] v);
    logic [31:0] w;
    begin
      w = 32'(v);
      if (w == 32'd0) begin
        w = 32'd1;
      end else if (w > 32'(MAX_DIM)) begin
        w = 32'(MAX_DIM);
      end
      return w[DW-1:0];
    end
  endfunction

  // Configuration is always accepted (cfg_ready is tied high).
  assign cfg_ready = 1'b1;

  always_comb begin
    row_cfg_nxt = row_cfg_r;
    col_cfg_nxt = col_cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_ROW_COUNT: row_cfg_nxt = cfg_data;
        CFG_COL_COUNT: col_cfg_nxt = cfg_data;
        default: begin
          row_cfg_nxt = row_cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_cfg_r <= CFG_W'(64);
      col_cfg_r <= CFG_W'(64);
    end else begin
      row_cfg_r <= row_cfg_nxt;
      col_cfg_r <= col_cfg_nxt;
    end
  end

  // Geometry in use; the user must change registers only while the block is idle (not enforced).
  assign rows  = clamp_dim(row_cfg_r);
  assign cols  = clamp_dim(col_cfg_r);
  assign total = IW'(IW'(rows) * IW'(cols));

  // Front end: classify each cell transfer as stored or dropped.
  gmca_front #(
    .IW(IW)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .total    (total),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (push_cmd)
  );

  // Short queue lets loading proceed while the fill engine drains.
  gmca_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .pop_cmd  (pop_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  // Back end: store cells, flood-fill regions, hold the result register.
  gmca_fill #(
    .CELLS (CELLS),
    .AW    (AW),
    .IW    (IW),
    .DW    (DW),
    .CW    (CW)
  ) u_fill (
    .clk       (clk),
    .rst_n     (rst_n),
    .cols      (cols),
    .total     (total),
    .q_empty   (q_empty),
    .q_cmd     (pop_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

endmodule

/* sv/gmca_front.sv */
// Front end: accepts cells, tracks the load position and classifies each cell.
`timescale 1ns / 1ps
module gmca_front import gmca_pkg::*; #(
  parameter int IW = 13
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  in_item_t      in_data,
  output logic          in_stall,
  input  logic [IW-1:0] total,
  input  logic          q_full,
  output logic          q_push,
  output cmd_t          q_cmd
);

  logic [IW-1:0] load_pos_r, load_pos_nxt;
  logic          store;

  assign store    = load_pos_r < total;
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  assign q_cmd.cell_open = in_data.cell_open;
  assign q_cmd.last_cell = in_data.last_cell;
  assign q_cmd.store     = store;

  always_comb begin
    load_pos_nxt = load_pos_r;
    if (q_push) begin
      if (in_data.last_cell) begin
        load_pos_nxt = '0;
      end else if (store) begin
        load_pos_nxt = load_pos_r + IW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_pos_r <= '0;
    end else begin
      load_pos_r <= load_pos_nxt;
    end
  end

endmodule

/* sv/gmca_cmd_fifo.sv */
// Two-entry queue of classified cells between the front end and the fill engine.
`timescale 1ns / 1ps
module gmca_cmd_fifo import gmca_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t pop_cmd,
  output logic full,
  output logic empty
);

  cmd_t       mem_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full    = cnt_r == 2'd2;
  assign empty   = cnt_r == 2'd0;
  assign pop_cmd = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? !wp_r : wp_r;
    rp_nxt  = pop ? !rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_cmd;
    end
  end

endmodule

/* sv/gmca_fill.sv */
// Back end: stores the grid, runs the breadth-first fill and holds the result.
`timescale 1ns / 1ps
module gmca_fill import gmca_pkg::*; #(
  parameter int CELLS = 4096,
  parameter int AW    = 12,
  parameter int IW    = 13,
  parameter int DW    = 7,
  parameter int CW    = 6
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [DW-1:0] cols,
  input  logic [IW-1:0] total,
  input  logic          q_empty,
  input  cmd_t          q_cmd,
  output logic          q_pop,
  output logic          out_valid,
  output out_item_t     out_data,
  input  logic          out_stall
);

  localparam logic [3:0] ST_CLR     = 4'd0;
  localparam logic [3:0] ST_IDLE    = 4'd1;
  localparam logic [3:0] ST_SCAN_RD = 4'd2;
  localparam logic [3:0] ST_SCAN_CK = 4'd3;
  localparam logic [3:0] ST_POP     = 4'd4;
  localparam logic [3:0] ST_POP_WT  = 4'd5;
  localparam logic [3:0] ST_NB      = 4'd6;
  localparam logic [3:0] ST_NB_CK   = 4'd7;
  localparam logic [3:0] ST_DONE    = 4'd8;

  localparam logic [1:0] DIR_RIGHT = 2'd0;
  localparam logic [1:0] DIR_LEFT  = 2'd1;
  localparam logic [1:0] DIR_UP    = 2'd2;
  localparam logic [1:0] DIR_DOWN  = 2'd3;

  localparam int QW = AW + CW;

  logic          open_mem [CELLS];
  logic          vis_mem  [CELLS];
  logic [QW-1:0] q_mem    [CELLS];

  logic [3:0]    state_r, state_nxt;
  logic [IW-1:0] wpos_r, wpos_nxt;
  logic [IW-1:0] loaded_r, loaded_nxt;
  logic [IW-1:0] scan_r, scan_nxt;
  logic [CW-1:0] scol_r, scol_nxt;
  logic [IW-1:0] head_r, head_nxt;
  logic [IW-1:0] tail_r, tail_nxt;
  logic [IW-1:0] cur_r, cur_nxt;
  logic [CW-1:0] ccol_r, ccol_nxt;
  logic [1:0]    dir_r, dir_nxt;
  logic [IW-1:0] nidx_r, nidx_nxt;
  logic [CW-1:0] ncol_r, ncol_nxt;
  logic [IW-1:0] cnt_r, cnt_nxt;
  logic [IW-1:0] best_r, best_nxt;
  logic          any_r, any_nxt;
  logic [IW-1:0] clr_r, clr_nxt;
  logic [IW-1:0] clr_end_r, clr_end_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_data_r, out_data_nxt;

  logic          open_q, vis_q;
  logic [QW-1:0] q_rd;

  logic          open_we, open_wd;
  logic [AW-1:0] open_wa;
  logic          vis_we, vis_wd;
  logic [AW-1:0] vis_wa;
  logic          rd_en;
  logic [AW-1:0] rd_a;
  logic          q_we, q_re;
  logic [AW-1:0] q_wa, q_ra;
  logic [QW-1:0] q_wd;

  logic [IW-1:0] cols_ext;
  logic          nb_ok;
  logic [IW-1:0] nb_idx;
  logic [CW-1:0] nb_col;
  logic          scol_wrap;
  logic [IW+AREA_W-1:0] best_ext;

  assign cols_ext  = IW'(cols);
  assign scol_wrap = (DW'(scol_r) + DW'(1)) == cols;
  assign best_ext  = {{AREA_W{1'b0}}, best_r};
  assign q_pop     = (state_r == ST_IDLE) && !q_empty;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // neighbor of the current cell in the present direction
  always_comb begin
    nb_ok  = 1'b0;
    nb_idx = cur_r;
    nb_col = ccol_r;
    case (dir_r)
      DIR_RIGHT: begin
        nb_ok  = (DW'(ccol_r) + DW'(1)) < cols;
        nb_idx = cur_r + IW'(1);
        nb_col = ccol_r + CW'(1);
      end
      DIR_LEFT: begin
        nb_ok  = ccol_r != '0;
        nb_idx = cur_r - IW'(1);
        nb_col = ccol_r - CW'(1);
      end
      DIR_UP: begin
        nb_ok  = cur_r >= cols_ext;
        nb_idx = cur_r - cols_ext;
      end
      DIR_DOWN: begin
        nb_ok  = (cur_r + cols_ext) < total;
        nb_idx = cur_r + cols_ext;
      end
      default: begin
        nb_ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    wpos_nxt      = wpos_r;
    loaded_nxt    = loaded_r;
    scan_nxt      = scan_r;
    scol_nxt      = scol_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    cur_nxt       = cur_r;
    ccol_nxt      = ccol_r;
    dir_nxt       = dir_r;
    nidx_nxt      = nidx_r;
    ncol_nxt      = ncol_r;
    cnt_nxt       = cnt_r;
    best_nxt      = best_r;
    any_nxt       = any_r;
    clr_nxt       = clr_r;
    clr_end_nxt   = clr_end_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    open_we = 1'b0;
    open_wa = wpos_r[AW-1:0];
    open_wd = q_cmd.cell_open;
    vis_we  = 1'b0;
    vis_wa  = clr_r[AW-1:0];
    vis_wd  = 1'b0;
    rd_en   = 1'b0;
    rd_a    = scan_r[AW-1:0];
    q_we    = 1'b0;
    q_wa    = tail_r[AW-1:0];
    q_wd    = {nidx_r[AW-1:0], ncol_r};
    q_re    = 1'b0;
    q_ra    = head_r[AW-1:0];
    case (state_r)
      ST_CLR: begin
        vis_we  = 1'b1;
        clr_nxt = clr_r + IW'(1);
        if (clr_nxt == clr_end_r) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!q_empty) begin
          if (q_cmd.store) begin
            open_we  = 1'b1;
            wpos_nxt = wpos_r + IW'(1);
          end
          if (q_cmd.last_cell) begin
            loaded_nxt = wpos_r + IW'(q_cmd.store);
            wpos_nxt   = '0;
            scan_nxt   = '0;
            scol_nxt   = '0;
            any_nxt    = 1'b0;
            state_nxt  = ST_SCAN_RD;
          end
        end
      end
      ST_SCAN_RD: begin
        if (scan_r == total) begin
          state_nxt = ST_DONE;
        end else begin
          rd_en     = 1'b1;
          state_nxt = ST_SCAN_CK;
        end
      end
      ST_SCAN_CK: begin
        if (scan_r < loaded_r && open_q && !vis_q) begin
          // seed a new region
          vis_we    = 1'b1;
          vis_wa    = scan_r[AW-1:0];
          vis_wd    = 1'b1;
          q_we      = 1'b1;
          q_wa      = '0;
          q_wd      = {scan_r[AW-1:0], scol_r};
          head_nxt  = '0;
          tail_nxt  = IW'(1);
          cnt_nxt   = '0;
          state_nxt = ST_POP;
        end else begin
          scan_nxt  = scan_r + IW'(1);
          scol_nxt  = scol_wrap ? '0 : scol_r + CW'(1);
          state_nxt = ST_SCAN_RD;
        end
      end
      ST_POP: begin
        if (head_r == tail_r) begin
          if (!any_r || cnt_r < best_r) begin
            best_nxt = cnt_r;
          end
          any_nxt   = 1'b1;
          scan_nxt  = scan_r + IW'(1);
          scol_nxt  = scol_wrap ? '0 : scol_r + CW'(1);
          state_nxt = ST_SCAN_RD;
        end else begin
          q_re      = 1'b1;
          state_nxt = ST_POP_WT;
        end
      end
      ST_POP_WT: begin
        cur_nxt   = IW'(q_rd[QW-1:CW]);
        ccol_nxt  = q_rd[CW-1:0];
        cnt_nxt   = cnt_r + IW'(1);
        head_nxt  = head_r + IW'(1);
        dir_nxt   = DIR_RIGHT;
        state_nxt = ST_NB;
      end
      ST_NB: begin
        if (nb_ok) begin
          rd_en     = 1'b1;
          rd_a      = nb_idx[AW-1:0];
          nidx_nxt  = nb_idx;
          ncol_nxt  = nb_col;
          state_nxt = ST_NB_CK;
        end else if (dir_r == DIR_DOWN) begin
          state_nxt = ST_POP;
        end else begin
          dir_nxt = dir_r + 2'd1;
        end
      end
      ST_NB_CK: begin
        if (nidx_r < loaded_r && open_q && !vis_q) begin
          vis_we   = 1'b1;
          vis_wa   = nidx_r[AW-1:0];
          vis_wd   = 1'b1;
          q_we     = 1'b1;
          tail_nxt = tail_r + IW'(1);
        end
        if (dir_r == DIR_DOWN) begin
          state_nxt = ST_POP;
        end else begin
          dir_nxt   = dir_r + 2'd1;
          state_nxt = ST_NB;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.no_component = !any_r;
          out_data_nxt.min_area     = any_r ? best_ext[AREA_W-1:0] : '0;
          clr_nxt                   = '0;
          clr_end_nxt               = total;
          state_nxt                 = ST_CLR;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      wpos_r      <= '0;
      any_r       <= 1'b0;
      clr_r       <= '0;
      clr_end_r   <= IW'(CELLS);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wpos_r      <= wpos_nxt;
      any_r       <= any_nxt;
      clr_r       <= clr_nxt;
      clr_end_r   <= clr_end_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    loaded_r   <= loaded_nxt;
    scan_r     <= scan_nxt;
    scol_r     <= scol_nxt;
    head_r     <= head_nxt;
    tail_r     <= tail_nxt;
    cur_r      <= cur_nxt;
    ccol_r     <= ccol_nxt;
    dir_r      <= dir_nxt;
    nidx_r     <= nidx_nxt;
    ncol_r     <= ncol_nxt;
    cnt_r      <= cnt_nxt;
    best_r     <= best_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (open_we) begin
      open_mem[open_wa] <= open_wd;
    end
    if (rd_en) begin
      open_q <= open_mem[rd_a];
    end
  end

  always_ff @(posedge clk) begin
    if (vis_we) begin
      vis_mem[vis_wa] <= vis_wd;
    end
    if (rd_en) begin
      vis_q <= vis_mem[rd_a];
    end
  end

  always_ff @(posedge clk) begin
    if (q_we) begin
      q_mem[q_wa] <= q_wd;
    end
    if (q_re) begin
      q_rd <= q_mem[q_ra];
    end
  end

endmodule
